// ----- hw/rtl/brb_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the
// circular byte FIFO. No dependencies; used by every module of the block but brb_ram.
`default_nettype none

package brb_pkg;

  localparam int DEPTH   = 1024;
  localparam int MAX_RUN = 64;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 11;
  localparam int RUN_W  = $clog2(MAX_RUN + 1);
  localparam int BYTE_W = 8;
  localparam int DATA_W = 32;
  localparam int PADDR_W = 3;

  localparam logic [1:0] OP_PUT  = 2'd0;
  localparam logic [1:0] OP_GET  = 2'd1;
  localparam logic [1:0] OP_SKIP = 2'd2;
  localparam logic [1:0] OP_PEEK = 2'd3;

  // Register index, taken from paddr above the byte lane bits.
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic item_load;
    logic exec_put;
    logic exec_skip;
    logic emit_none;
    logic read_setup;
    logic read_issue;
    logic read_emit;
  } brb_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       put_ends;
    logic       get_n_zero;
    logic       read_last;
    logic       out_free;
  } brb_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/brb_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/brb_ctrl.sv -----
// Controller state machine of the circular byte FIFO: sequences each word
// through execute and byte read steps. Depends on brb_pkg.
`default_nettype none

module brb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire brb_pkg::brb_stat_t stat,
  output brb_pkg::brb_cmd_t     cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_DATA = 2'd3;

  logic [1:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.item_load = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.op)
          brb_pkg::OP_PUT: begin
            // A put word that does not end its run has no result to wait on.
            if (!stat.put_ends || stat.out_free) begin
              cmd.exec_put = 1'b1;
              state_next   = S_IDLE;
            end
          end
          brb_pkg::OP_SKIP: begin
            if (stat.out_free) begin
              cmd.exec_skip = 1'b1;
              state_next    = S_IDLE;
            end
          end
          brb_pkg::OP_GET, brb_pkg::OP_PEEK: begin
            priority if (stat.get_n_zero) begin
              if (stat.out_free) begin
                cmd.emit_none = 1'b1;
                state_next    = S_IDLE;
              end
            end else begin
              cmd.read_setup = 1'b1;
              state_next     = S_READ;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_READ: begin
        cmd.read_issue = 1'b1;
        state_next     = S_DATA;
      end
      S_DATA: begin
        if (stat.out_free) begin
          cmd.read_emit = 1'b1;
          state_next    = stat.read_last ? S_IDLE : S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/brb_dp.sv -----
// Datapath of the circular byte FIFO: capacity register, pointers, put run
// state, byte store and output register. Depends on brb_pkg and brb_ram.
`default_nettype none

module brb_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [brb_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [brb_pkg::DATA_W-1:0]        pwdata,
  output logic      [brb_pkg::DATA_W-1:0]        prdata,
  // input word
  input  wire logic [1:0]                        operation,
  input  wire logic [brb_pkg::CNT_W-1:0]         request_count,
  input  wire logic [brb_pkg::BYTE_W-1:0]        data_byte,
  input  wire logic                              last_in,
  // result word
  output logic                                   result_valid,
  input  wire logic                              result_ready,
  output logic      [brb_pkg::BYTE_W-1:0]        read_byte,
  output logic                                   byte_valid,
  output logic      [brb_pkg::CNT_W-1:0]         done_count,
  output logic                                   last_out,
  // controller link
  input  wire brb_pkg::brb_cmd_t                 cmd,
  output brb_pkg::brb_stat_t                     stat
);

  localparam int CNT_W  = brb_pkg::CNT_W;
  localparam int RUN_W  = brb_pkg::RUN_W;
  localparam int ADDR_W = brb_pkg::ADDR_W;
  localparam int PAD_W  = CNT_W - RUN_W;

  logic [CNT_W-1:0]  capacity;
  logic [CNT_W-1:0]  fill;
  logic [ADDR_W-1:0] rd_ptr;
  logic [ADDR_W-1:0] rd_addr;
  logic [RUN_W-1:0]  run_received;
  logic              run_accepting;
  logic [RUN_W-1:0]  read_n;
  logic [RUN_W-1:0]  read_i;

  logic [1:0]                  item_op;
  logic [RUN_W-1:0]            item_req;
  logic [brb_pkg::BYTE_W-1:0]  item_data;
  logic                        item_last;

  logic                        cfg_wr;
  logic [CNT_W-1:0]            cfg_cap;
  logic [RUN_W-1:0]            req_sat;
  logic [RUN_W-1:0]            put_len;
  logic [CNT_W-1:0]            free_space;
  logic                        accept_now;
  logic                        put_wr;
  logic [ADDR_W-1:0]           put_addr;
  logic [RUN_W-1:0]            recv_next;
  logic                        put_ends;
  logic [RUN_W-1:0]            get_n;
  logic [RUN_W-1:0]            skip_n;
  logic [ADDR_W-1:0]           skip_ptr;
  logic [ADDR_W-1:0]           addr_adv;
  logic                        read_last;
  logic                        out_free;
  logic [brb_pkg::BYTE_W-1:0]  ram_rdata;

  // Offset from a slot, wrapped at the capacity. The base stays below the
  // capacity and the offset does not exceed it, so one conditional subtract is enough.
  function automatic logic [ADDR_W-1:0] wrap_slot(input logic [ADDR_W-1:0] base,
                                                  input logic [CNT_W-1:0]  off,
                                                  input logic [CNT_W-1:0]  cap);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, base} + {1'b0, off};
    if (sum >= {1'b0, cap}) begin
      sum = sum - {1'b0, cap};
    end
    return sum[ADDR_W-1:0];
  endfunction

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == brb_pkg::REG_CAPACITY);

  always_comb begin
    cfg_cap = pwdata[CNT_W-1:0];
    priority if (cfg_cap == '0) begin
      cfg_cap = CNT_W'(1);
    end else if (cfg_cap > CNT_W'(brb_pkg::DEPTH)) begin
      cfg_cap = CNT_W'(brb_pkg::DEPTH);
    end else begin
      cfg_cap = pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == brb_pkg::REG_CAPACITY)
                  ? {{(brb_pkg::DATA_W - CNT_W){1'b0}}, capacity} : '0;

  assign req_sat = (request_count > CNT_W'(brb_pkg::MAX_RUN))
                   ? RUN_W'(brb_pkg::MAX_RUN) : request_count[RUN_W-1:0];

  // Put run: acceptance is decided on the first word of the run only.
  assign put_len    = (item_req == '0) ? RUN_W'(1) : item_req;
  assign free_space = capacity - fill;
  assign accept_now = (run_received == '0) ? (free_space > {{PAD_W{1'b0}}, put_len})
                                           : run_accepting;
  assign put_wr     = cmd.exec_put && accept_now && (fill < capacity);
  assign put_addr   = wrap_slot(rd_ptr, fill, capacity);
  assign recv_next  = run_received + RUN_W'(1);
  assign put_ends   = item_last || (recv_next >= put_len);

  assign get_n    = ({{PAD_W{1'b0}}, item_req} < fill) ? item_req : fill[RUN_W-1:0];
  assign skip_n   = ({{PAD_W{1'b0}}, item_req} <= fill) ? item_req : '0;
  assign skip_ptr = wrap_slot(rd_ptr, {{PAD_W{1'b0}}, skip_n}, capacity);

  assign addr_adv  = ({1'b0, rd_addr} + CNT_W'(1) == capacity) ? '0
                     : rd_addr + ADDR_W'(1);
  assign read_last = (read_i + RUN_W'(1) == read_n);
  assign out_free  = !result_valid || result_ready;

  assign stat.op         = item_op;
  assign stat.put_ends   = put_ends;
  assign stat.get_n_zero = (get_n == '0);
  assign stat.read_last  = read_last;
  assign stat.out_free   = out_free;

  brb_ram #(
    .WIDTH (brb_pkg::BYTE_W),
    .DEPTH (brb_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (put_wr),
    .wr_addr (put_addr),
    .wr_data (item_data),
    .rd_en   (cmd.read_issue),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_op   <= operation;
      item_req  <= req_sat;
      item_data <= data_byte;
      item_last <= last_in;
    end
    if (cmd.read_setup) begin
      read_n  <= get_n;
      read_i  <= '0;
      rd_addr <= rd_ptr;
    end else if (cmd.read_emit) begin
      read_i  <= read_i + RUN_W'(1);
      rd_addr <= addr_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= CNT_W'(brb_pkg::DEPTH);
      fill          <= '0;
      rd_ptr        <= '0;
      run_received  <= '0;
      run_accepting <= 1'b0;
    end else if (cfg_wr) begin
      capacity      <= cfg_cap;
      fill          <= '0;
      rd_ptr        <= '0;
      run_received  <= '0;
      run_accepting <= 1'b0;
    end else begin
      if (cmd.exec_put) begin
        if (put_wr) begin
          fill <= fill + CNT_W'(1);
        end
        if (put_ends) begin
          run_received  <= '0;
          run_accepting <= 1'b0;
        end else begin
          run_received  <= recv_next;
          run_accepting <= accept_now;
        end
      end
      if (cmd.exec_skip) begin
        rd_ptr <= skip_ptr;
        fill   <= fill - {{PAD_W{1'b0}}, skip_n};
      end
      // A get consumes its bytes once the final one is handed on; peek does not.
      if (cmd.read_emit && read_last && (item_op == brb_pkg::OP_GET)) begin
        rd_ptr <= addr_adv;
        fill   <= fill - {{PAD_W{1'b0}}, read_n};
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((cmd.exec_put && put_ends) || cmd.exec_skip || cmd.emit_none
                 || cmd.read_emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.exec_put && put_ends) begin
      read_byte  <= '0;
      byte_valid <= 1'b0;
      done_count <= accept_now ? {{PAD_W{1'b0}}, recv_next} : '0;
      last_out   <= 1'b1;
    end else if (cmd.exec_skip) begin
      read_byte  <= '0;
      byte_valid <= 1'b0;
      done_count <= {{PAD_W{1'b0}}, skip_n};
      last_out   <= 1'b1;
    end else if (cmd.emit_none) begin
      read_byte  <= '0;
      byte_valid <= 1'b0;
      done_count <= '0;
      last_out   <= 1'b1;
    end else if (cmd.read_emit) begin
      read_byte  <= ram_rdata;
      byte_valid <= 1'b1;
      done_count <= {{PAD_W{1'b0}}, read_n};
      last_out   <= read_last;
    end else begin
      read_byte  <= read_byte;
      byte_valid <= byte_valid;
      done_count <= done_count;
      last_out   <= last_out;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/byte_ring_buffer.sv -----
// Top level of the circular byte FIFO: joins the controller and the datapath.
// Depends on brb_pkg, brb_ctrl, brb_dp and brb_ram.
//
//   channel   handshake                  payload
//   -------   -------------------------  ----------------------------------------
//   item      item_valid / item_ready    operation, request_count, data_byte, last_in
//   result    result_valid/result_ready  read_byte, byte_valid, done_count, last_out
//   config    psel, penable, pready      paddr, pwrite, pwdata, prdata
//
// A put or skip word passes through an accept step and an execute step. A get or
// peek word adds, for each of its n returned bytes, an address step and a data
// step on the single registered read port of the byte store.
// Reset is synchronous; the byte store needs no clearing pass after it.
// A full output register stalls only the step that would load it; a new word
// is accepted while the last result still waits to be taken.
`default_nettype none

module byte_ring_buffer (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [brb_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [brb_pkg::DATA_W-1:0]     pwdata,
  output logic      [brb_pkg::DATA_W-1:0]     prdata,
  output logic                                pready,
  input  wire logic                           item_valid,
  output logic                                item_ready,
  input  wire logic [1:0]                     operation,
  input  wire logic [brb_pkg::CNT_W-1:0]      request_count,
  input  wire logic [brb_pkg::BYTE_W-1:0]     data_byte,
  input  wire logic                           last_in,
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output logic      [brb_pkg::BYTE_W-1:0]     read_byte,
  output logic                                byte_valid,
  output logic      [brb_pkg::CNT_W-1:0]      done_count,
  output logic                                last_out
);

  brb_pkg::brb_cmd_t  cmd;
  brb_pkg::brb_stat_t stat;

  assign pready = 1'b1;

  brb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  brb_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .operation     (operation),
    .request_count (request_count),
    .data_byte     (data_byte),
    .last_in       (last_in),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .read_byte     (read_byte),
    .byte_valid    (byte_valid),
    .done_count    (done_count),
    .last_out      (last_out),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

`default_nettype wire
